// File: design/assert_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// File: design/pnmhp_pkg.sv
// Package with the types, codes and helpers of the PNM header parser.
`timescale 1ns / 1ps
package pnmhp_pkg;

  localparam int DEF_HEADER_BYTES = 2048;
  localparam int DEF_NUMBER_BITS  = 16;
  localparam int OFFSET_W         = 12;
  localparam int DIM_W            = 16;

  localparam logic [1:0] ERR_OK       = 2'd0;
  localparam logic [1:0] ERR_MAGIC    = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW = 2'd2;
  localparam logic [1:0] ERR_NUMBER   = 2'd3;

  localparam logic [7:0] CHAR_P    = 8'h50;
  localparam logic [7:0] CHAR_2    = 8'h32;
  localparam logic [7:0] CHAR_3    = 8'h33;
  localparam logic [7:0] CHAR_5    = 8'h35;
  localparam logic [7:0] CHAR_6    = 8'h36;
  localparam logic [7:0] CHAR_0    = 8'h30;
  localparam logic [7:0] CHAR_HASH = 8'h23;
  localparam logic [7:0] CHAR_LF   = 8'h0a;

  localparam logic [1:0] FMT_P2 = 2'd0;
  localparam logic [1:0] FMT_P3 = 2'd1;
  localparam logic [1:0] FMT_P5 = 2'd2;
  localparam logic [1:0] FMT_P6 = 2'd3;

  typedef enum logic [8:0] {
    PH_MAGIC1 = 9'b000000001,
    PH_MAGIC2 = 9'b000000010,
    PH_PRE    = 9'b000000100,
    PH_WIDTH  = 9'b000001000,
    PH_WS_H   = 9'b000010000,
    PH_HEIGHT = 9'b000100000,
    PH_WS_M   = 9'b001000000,
    PH_MAX    = 9'b010000000,
    PH_DONE   = 9'b100000000
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_req;
  } beat_t;

  typedef struct packed {
    logic [1:0]          error_code;
    logic [1:0]          image_format;
    logic [1:0]          components;
    logic [4:0]          bits_per_component;
    logic [DIM_W-1:0]    image_width;
    logic [DIM_W-1:0]    image_height;
    logic [DIM_W-1:0]    max_value;
    logic [OFFSET_W-1:0] data_offset;
  } result_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'd32) || (c inside {[8'd9:8'd13]});
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'd48:8'd57]};
  endfunction

endpackage

// File: design/pnm_header_parser_unit.sv
// A byte-serial PNM header parser that takes one file byte per cycle and gives one
// result when the header ends or fails. Each byte passes through an input register
// and is then parsed combinationally into the result register, so the block
// sustains one byte per clock, and the result is loaded into the result register
// when the input register passes on the byte that ends the header. It stalls only
// while a result sits in the result register and is not taken. After a result,
// bytes are accepted and dropped until a beat with start_req set begins a new file.
`timescale 1ns / 1ps
module pnm_header_parser_unit #(
  parameter int HEADER_BYTES = pnmhp_pkg::DEF_HEADER_BYTES,
  parameter int NUMBER_BITS  = pnmhp_pkg::DEF_NUMBER_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     data_byte,
  input  logic                           start_req,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     error_code,
  output logic [1:0]                     image_format,
  output logic [1:0]                     components,
  output logic [4:0]                     bits_per_component,
  output logic [pnmhp_pkg::DIM_W-1:0]    image_width,
  output logic [pnmhp_pkg::DIM_W-1:0]    image_height,
  output logic [pnmhp_pkg::DIM_W-1:0]    max_value,
  output logic [pnmhp_pkg::OFFSET_W-1:0] data_offset
);
  import pnmhp_pkg::*;

  beat_t   in_beat;
  beat_t   held_beat;
  logic    advance;
  logic    fire;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign in_beat.data_byte = data_byte;
  assign in_beat.start_req = start_req;

  pnmhp_in_reg u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_beat   (in_beat),
    .advance   (advance),
    .fire      (fire),
    .held_beat (held_beat)
  );

  pnmhp_core #(
    .HEADER_BYTES (HEADER_BYTES),
    .NUMBER_BITS  (NUMBER_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .beat      (held_beat),
    .res_valid (res_valid),
    .res       (res)
  );

  pnmhp_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (fire && res_valid),
    .load_res  (res),
    .advance   (advance),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign error_code         = out_res.error_code;
  assign image_format       = out_res.image_format;
  assign components         = out_res.components;
  assign bits_per_component = out_res.bits_per_component;
  assign image_width        = out_res.image_width;
  assign image_height       = out_res.image_height;
  assign max_value          = out_res.max_value;
  assign data_offset        = out_res.data_offset;

endmodule

// File: design/pnmhp_in_reg.sv
// Input register stage that holds one accepted byte beat.
`timescale 1ns / 1ps
module pnmhp_in_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  pnmhp_pkg::beat_t in_beat,
  input  logic           advance,
  output logic           fire,
  output pnmhp_pkg::beat_t held_beat
);
  import pnmhp_pkg::*;

  logic held_valid;

  assign in_ready = !held_valid || advance;
  assign fire     = held_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_beat <= in_beat;
    end
  end

endmodule

// File: design/pnmhp_core.sv
// Parser state and the per-byte next-state and result logic.
`timescale 1ns / 1ps
module pnmhp_core #(
  parameter int HEADER_BYTES = pnmhp_pkg::DEF_HEADER_BYTES,
  parameter int NUMBER_BITS  = pnmhp_pkg::DEF_NUMBER_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  pnmhp_pkg::beat_t   beat,
  output logic               res_valid,
  output pnmhp_pkg::result_t res
);
  import pnmhp_pkg::*;

  localparam int SumW  = NUMBER_BITS + 4;
  localparam int WideW = NUMBER_BITS + DIM_W;
  localparam int PosW  = OFFSET_W + 1;

  phase_t               phase, phase_next, cur_phase;
  logic                 saw_p, saw_p_next, cur_saw_p;
  logic [1:0]           fmt, fmt_next, cur_fmt;
  logic                 in_comment, in_comment_next, cur_in_comment;
  logic [NUMBER_BITS-1:0] acc, acc_next, cur_acc;
  logic [DIM_W-1:0]     width_held, width_next, cur_width;
  logic [DIM_W-1:0]     height_held, height_next, cur_height;
  logic [OFFSET_W-1:0]  pos, pos_next, cur_pos;

  logic [7:0]           c;
  logic [3:0]           dval;
  logic [SumW-1:0]      sum;
  logic                 over;
  logic [WideW-1:0]     acc_wide;
  logic [PosW-1:0]      newpos;
  logic [1:0]           err;
  logic                 done_ok;
  logic                 ignore;
  logic [4:0]           bpc;

  always_comb begin
    c    = beat.data_byte;
    dval = 4'(c - CHAR_0);

    if (beat.start_req) begin
      cur_phase      = PH_MAGIC1;
      cur_saw_p      = 1'b0;
      cur_fmt        = 2'd0;
      cur_in_comment = 1'b0;
      cur_acc        = '0;
      cur_width      = '0;
      cur_height     = '0;
      cur_pos        = '0;
    end else begin
      cur_phase      = phase;
      cur_saw_p      = saw_p;
      cur_fmt        = fmt;
      cur_in_comment = in_comment;
      cur_acc        = acc;
      cur_width      = width_held;
      cur_height     = height_held;
      cur_pos        = pos;
    end

    sum      = SumW'({cur_acc, 3'b000}) + SumW'({cur_acc, 1'b0}) + SumW'(dval);
    over     = |sum[SumW-1:NUMBER_BITS];
    acc_wide = WideW'(cur_acc);
    newpos   = PosW'(cur_pos) + PosW'(1);

    bpc = 5'd0;
    for (int n = 1; n <= 16; n++) begin
      if (acc_wide == WideW'((64'd1 << n) - 64'd1)) begin
        bpc = 5'(n);
      end
    end

    phase_next      = cur_phase;
    saw_p_next      = cur_saw_p;
    fmt_next        = cur_fmt;
    in_comment_next = cur_in_comment;
    acc_next        = cur_acc;
    width_next      = cur_width;
    height_next     = cur_height;
    pos_next        = cur_pos;
    err             = ERR_OK;
    done_ok         = 1'b0;
    ignore          = 1'b0;

    case (cur_phase)
      PH_MAGIC1: begin
        if (!is_ws(c)) begin
          saw_p_next = (c == CHAR_P);
          phase_next = PH_MAGIC2;
        end
      end
      PH_MAGIC2: begin
        if (!is_ws(c)) begin
          if (cur_saw_p && c == CHAR_2) fmt_next = FMT_P2;
          else if (cur_saw_p && c == CHAR_3) fmt_next = FMT_P3;
          else if (cur_saw_p && c == CHAR_5) fmt_next = FMT_P5;
          else if (cur_saw_p && c == CHAR_6) fmt_next = FMT_P6;
          else err = ERR_MAGIC;
          phase_next = PH_PRE;
        end
      end
      PH_PRE: begin
        if (cur_in_comment) begin
          if (c == CHAR_LF) in_comment_next = 1'b0;
        end else if (c == CHAR_HASH) begin
          in_comment_next = 1'b1;
        end else if (is_digit(c)) begin
          acc_next   = NUMBER_BITS'(dval);
          phase_next = PH_WIDTH;
        end else if (!is_ws(c)) begin
          err = ERR_NUMBER;
        end
      end
      PH_WS_H, PH_WS_M: begin
        if (is_digit(c)) begin
          acc_next   = NUMBER_BITS'(dval);
          phase_next = (cur_phase == PH_WS_H) ? PH_HEIGHT : PH_MAX;
        end else if (!is_ws(c)) begin
          err = ERR_NUMBER;
        end
      end
      PH_WIDTH, PH_HEIGHT: begin
        if (is_digit(c)) begin
          if (over) err = ERR_NUMBER;
          else acc_next = sum[NUMBER_BITS-1:0];
        end else if (is_ws(c)) begin
          if (cur_phase == PH_WIDTH) begin
            width_next = acc_wide[DIM_W-1:0];
            phase_next = PH_WS_H;
          end else begin
            height_next = acc_wide[DIM_W-1:0];
            phase_next  = PH_WS_M;
          end
          acc_next = '0;
        end else begin
          err = ERR_NUMBER;
        end
      end
      PH_MAX: begin
        if (is_digit(c)) begin
          if (over) err = ERR_NUMBER;
          else acc_next = sum[NUMBER_BITS-1:0];
        end else if (bpc == 5'd0) begin
          err = ERR_NUMBER;
        end else begin
          done_ok = 1'b1;
        end
      end
      default: begin
        ignore = 1'b1;
      end
    endcase

    if (err == ERR_OK && newpos >= PosW'(HEADER_BYTES)) begin
      err = ERR_OVERFLOW;
    end

    res_valid = !ignore && (err != ERR_OK || done_ok);
    if (!ignore) begin
      pos_next = newpos[OFFSET_W-1:0];
    end
    if (res_valid) begin
      phase_next = PH_DONE;
    end

    res = '0;
    res.error_code = err;
    if (err == ERR_OK) begin
      res.image_format       = fmt_next;
      res.components         = fmt_next[0] ? 2'd3 : 2'd1;
      res.bits_per_component = bpc;
      res.image_width        = cur_width;
      res.image_height       = cur_height;
      res.max_value          = acc_wide[DIM_W-1:0];
      res.data_offset        = newpos[OFFSET_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_MAGIC1;
      saw_p       <= 1'b0;
      fmt         <= 2'd0;
      in_comment  <= 1'b0;
      acc         <= '0;
      width_held  <= '0;
      height_held <= '0;
      pos         <= '0;
    end else if (fire) begin
      phase       <= phase_next;
      saw_p       <= saw_p_next;
      fmt         <= fmt_next;
      in_comment  <= in_comment_next;
      acc         <= acc_next;
      width_held  <= width_next;
      height_held <= height_next;
      pos         <= pos_next;
    end
  end

endmodule

// File: design/pnmhp_out_reg.sv
// Result register that holds one header result until it is taken.
`timescale 1ns / 1ps
module pnmhp_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  pnmhp_pkg::result_t load_res,
  output logic               advance,
  output logic               out_valid,
  input  logic               out_ready,
  output pnmhp_pkg::result_t out_res
);
  import pnmhp_pkg::*;

  assign advance = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && load) begin
      out_res <= load_res;
    end
  end

endmodule

// File: design/pnmhp_checker.sv
// Port-level checker for the PNM header parser and its bind statement.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pnmhp_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [1:0]                     error_code,
  input logic [1:0]                     image_format,
  input logic [1:0]                     components,
  input logic [4:0]                     bits_per_component,
  input logic [pnmhp_pkg::DIM_W-1:0]    image_width,
  input logic [pnmhp_pkg::DIM_W-1:0]    image_height,
  input logic [pnmhp_pkg::DIM_W-1:0]    max_value,
  input logic [pnmhp_pkg::OFFSET_W-1:0] data_offset
);
  import pnmhp_pkg::*;

  logic ok_beat;
  logic err_beat;

  assign ok_beat  = out_valid && error_code == ERR_OK;
  assign err_beat = out_valid && error_code != ERR_OK;

  `ASSERT_IMPL(a_err_fields_zero, clk, rst, err_beat, image_format == 2'd0 && components == 2'd0 && bits_per_component == 5'd0 && image_width == '0 && image_height == '0 && max_value == '0 && data_offset == '0)
  `ASSERT_IMPL(a_ok_components, clk, rst, ok_beat, components == (image_format[0] ? 2'd3 : 2'd1))
  `ASSERT_IMPL(a_ok_depth, clk, rst, ok_beat, bits_per_component != 5'd0 && bits_per_component <= 5'd16 && max_value == 16'((17'd1 << bits_per_component) - 17'd1))
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(error_code) && $stable(max_value) && $stable(data_offset))

endmodule

bind pnm_header_parser_unit pnmhp_checker u_pnmhp_checker (
  .clk                (clk),
  .rst                (rst),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .error_code         (error_code),
  .image_format       (image_format),
  .components         (components),
  .bits_per_component (bits_per_component),
  .image_width        (image_width),
  .image_height       (image_height),
  .max_value          (max_value),
  .data_offset        (data_offset)
);
